### hw/rtl/ibcs_pkg.sv
// ----------------------------------------------------------------------------
// IMU bias calibration package
// Shared types and constants for the six-axis bias calibration and scaling
// block.
// ----------------------------------------------------------------------------
package ibcs_pkg;

  localparam int unsigned NUM_AXES = 6;
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned OUT_W    = 20;
  localparam int unsigned RANGE_W  = 2;
  localparam int unsigned SUM_W    = 23;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // Rounded average is (2*|sum| + N) / (2*N), done as a multiplication by a
  // rounded-up reciprocal of 2*N, which is exact for every dividend that fits
  // DVD_W bits.
  localparam int unsigned DVD_W   = 23;
  localparam int unsigned RECIP_W = DVD_W + 2;
  localparam int unsigned PROD_W  = DVD_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_RANGE = 8'd0,
    REG_GYRO_RANGE  = 8'd1
  } ibcs_reg_e;

  typedef enum logic [2:0] {
    ST_CALIB,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH,
    ST_RUN
  } ibcs_state_e;

  typedef struct packed {
    logic acc_en;
    logic div_load;
    logic div_step;
    logic bias_load;
  } ibcs_lane_ctrl_t;

endpackage

### hw/rtl/ibcs_lane.sv
// ----------------------------------------------------------------------------
// IMU bias calibration axis lane
// Accumulates one axis during calibration, divides the sum into a rounded
// bias, and then removes the bias and applies the range shift.
// ----------------------------------------------------------------------------
module ibcs_lane
  import ibcs_pkg::*;
#(
  parameter int unsigned CALIB_SAMPLES = 100
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ibcs_lane_ctrl_t          ctrl_i,
  input  logic signed [RAW_W-1:0]  raw_i,
  input  logic [RANGE_W-1:0]       range_i,
  output logic signed [OUT_W-1:0]  result_o
);

  localparam int unsigned      DIVISOR  = 2 * CALIB_SAMPLES;
  localparam int unsigned      DIV_LOG2 = $clog2(DIVISOR);
  localparam int unsigned      SHIFT    = DVD_W + DIV_LOG2;
  localparam logic [RECIP_W-1:0] RECIP  =
    RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam logic [DVD_W-1:0] ROUND_UP = DVD_W'(CALIB_SAMPLES);

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [RAW_W-1:0] bias_q, bias_d;
  logic [DVD_W-1:0]        dvd_q, dvd_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic                    neg_q, neg_d;

  logic [SUM_W-1:0]        mag;
  logic [RAW_W-1:0]        quot;
  logic signed [RAW_W:0]   diff;
  logic signed [OUT_W-1:0] diff_ext;

  always_comb begin
    mag  = sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
    quot = prod_q[SHIFT +: RAW_W];

    sum_d  = sum_q;
    bias_d = bias_q;
    dvd_d  = dvd_q;
    prod_d = prod_q;
    neg_d  = neg_q;

    if (ctrl_i.acc_en) begin
      sum_d = sum_q + {{(SUM_W-RAW_W){raw_i[RAW_W-1]}}, raw_i};
    end
    if (ctrl_i.div_load) begin
      neg_d = sum_q[SUM_W-1];
      dvd_d = {mag[DVD_W-2:0], 1'b0} + ROUND_UP;
    end
    if (ctrl_i.div_step) begin
      prod_d = PROD_W'(dvd_q) * PROD_W'(RECIP);
    end
    if (ctrl_i.bias_load) begin
      bias_d = neg_q ? (RAW_W'(0) - quot) : quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      bias_q <= '0;
    end else begin
      sum_q  <= sum_d;
      bias_q <= bias_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    prod_q <= prod_d;
    neg_q  <= neg_d;
  end

  // The difference needs 17 bits and the shift is at most three, so the
  // result always fits the output width.
  assign diff     = {raw_i[RAW_W-1], raw_i} - {bias_q[RAW_W-1], bias_q};
  assign diff_ext = {{(OUT_W-RAW_W-1){diff[RAW_W]}}, diff};
  assign result_o = diff_ext <<< range_i;

endmodule

### hw/rtl/ibcs_merge.sv
// ----------------------------------------------------------------------------
// IMU bias calibration result merge
// Gathers the six lane results into one registered result transaction.
// ----------------------------------------------------------------------------
module ibcs_merge
  import ibcs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic signed [OUT_W-1:0] lane_i [NUM_AXES],
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic                    free_o,
  output logic signed [OUT_W-1:0] data_o [NUM_AXES]
);

  logic                    valid_q, valid_d;
  logic signed [OUT_W-1:0] data_q [NUM_AXES];

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= lane_i;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

endmodule

### hw/rtl/ibcs_ctrl.sv
// ----------------------------------------------------------------------------
// IMU bias calibration controller
// Counts calibration samples, sequences the lane dividers and gates input
// transactions into the result path.
// ----------------------------------------------------------------------------
module ibcs_ctrl
  import ibcs_pkg::*;
#(
  parameter int unsigned CALIB_SAMPLES = 100
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_free_i,
  output logic            in_ready_o,
  output logic            out_load_o,
  output ibcs_lane_ctrl_t lane_ctrl_o
);

  localparam logic [COUNT_W-1:0] LAST_COUNT  = COUNT_W'(CALIB_SAMPLES - 1);
  localparam logic [COUNT_W-1:0] CALIB_COUNT = COUNT_W'(CALIB_SAMPLES);

  ibcs_state_e          state_q, state_d;
  logic [COUNT_W-1:0]   count_q, count_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CALIB: begin
        if (in_valid_i && (count_q == LAST_COUNT)) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD:   state_d = ST_DIVIDE;
      ST_DIVIDE: state_d = ST_FINISH;
      ST_FINISH: state_d = ST_RUN;
      ST_RUN:    state_d = ST_RUN;
      default:   state_d = ST_CALIB;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    out_load_o  = 1'b0;
    lane_ctrl_o = '0;
    case (state_q)
      ST_CALIB: begin
        in_ready_o         = 1'b1;
        lane_ctrl_o.acc_en = in_valid_i;
      end
      ST_LOAD:   lane_ctrl_o.div_load  = 1'b1;
      ST_DIVIDE: lane_ctrl_o.div_step  = 1'b1;
      ST_FINISH: lane_ctrl_o.bias_load = 1'b1;
      ST_RUN: begin
        in_ready_o = out_free_i;
        out_load_o = in_valid_i && out_free_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (lane_ctrl_o.acc_en) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CALIB;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CALIB && state_q != ST_RUN) |-> !in_ready_o)
    else $error("input accepted while the biases are being computed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> (state_q == ST_RUN))
    else $error("bias write not followed by normal operation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (count_q == CALIB_COUNT))
    else $error("sample count moved after calibration");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({lane_ctrl_o.acc_en, lane_ctrl_o.div_load,
              lane_ctrl_o.div_step, lane_ctrl_o.bias_load}))
    else $error("conflicting lane commands");

endmodule

### hw/rtl/imu_bias_calibrate_and_scale.sv
// ----------------------------------------------------------------------------
// IMU bias calibration and scaling
// Six-axis bias removal with range scaling; top level.
// ----------------------------------------------------------------------------
// After reset the first CALIB_SAMPLES sample transactions are summed per axis
// and produce no result. The block then computes the six biases with one
// reciprocal multiplication per axis lane and holds in_ready_o low through
// the dividend load, multiply and bias write. From then on every sample
// yields one result transaction with each axis reading minus its bias,
// shifted left by the range code; a sample is accepted every cycle while
// the output register is empty or being read, and its result appears in
// the cycle after acceptance. Range registers take effect on the next sample.
module imu_bias_calibrate_and_scale
  import ibcs_pkg::*;
#(
  parameter int unsigned CALIB_SAMPLES = 100
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [RAW_W-1:0] raw_accel_x_i,
  input  logic signed [RAW_W-1:0] raw_accel_y_i,
  input  logic signed [RAW_W-1:0] raw_accel_z_i,
  input  logic signed [RAW_W-1:0] raw_gyro_x_i,
  input  logic signed [RAW_W-1:0] raw_gyro_y_i,
  input  logic signed [RAW_W-1:0] raw_gyro_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] accel_x_out_o,
  output logic signed [OUT_W-1:0] accel_y_out_o,
  output logic signed [OUT_W-1:0] accel_z_out_o,
  output logic signed [OUT_W-1:0] gyro_x_out_o,
  output logic signed [OUT_W-1:0] gyro_y_out_o,
  output logic signed [OUT_W-1:0] gyro_z_out_o
);

  logic [RANGE_W-1:0]      accel_range_q, accel_range_d;
  logic [RANGE_W-1:0]      gyro_range_q, gyro_range_d;
  logic signed [RAW_W-1:0] raw [NUM_AXES];
  logic signed [OUT_W-1:0] lane_res [NUM_AXES];
  logic signed [OUT_W-1:0] merged [NUM_AXES];
  ibcs_lane_ctrl_t         lane_ctrl;
  logic                    out_free;
  logic                    out_load;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    accel_range_d = accel_range_q;
    gyro_range_d  = gyro_range_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ACCEL_RANGE: accel_range_d = cfg_data_i[RANGE_W-1:0];
        REG_GYRO_RANGE:  gyro_range_d  = cfg_data_i[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_range_q <= RANGE_W'(1);
      gyro_range_q  <= '0;
    end else begin
      accel_range_q <= accel_range_d;
      gyro_range_q  <= gyro_range_d;
    end
  end

  assign raw[0] = raw_accel_x_i;
  assign raw[1] = raw_accel_y_i;
  assign raw[2] = raw_accel_z_i;
  assign raw[3] = raw_gyro_x_i;
  assign raw[4] = raw_gyro_y_i;
  assign raw[5] = raw_gyro_z_i;

  ibcs_ctrl #(
    .CALIB_SAMPLES (CALIB_SAMPLES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_free_i  (out_free),
    .in_ready_o  (in_ready_o),
    .out_load_o  (out_load),
    .lane_ctrl_o (lane_ctrl)
  );

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    ibcs_lane #(
      .CALIB_SAMPLES (CALIB_SAMPLES)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .raw_i    (raw[g]),
      .range_i  ((g < NUM_AXES / 2) ? accel_range_q : gyro_range_q),
      .result_o (lane_res[g])
    );
  end

  ibcs_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .lane_i      (lane_res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .data_o      (merged)
  );

  assign accel_x_out_o = merged[0];
  assign accel_y_out_o = merged[1];
  assign accel_z_out_o = merged[2];
  assign gyro_x_out_o  = merged[3];
  assign gyro_y_out_o  = merged[4];
  assign gyro_z_out_o  = merged[5];

endmodule
